@@ rtl/mfr_pkg.sv @@
// Shared types and constants for the matrix flip/rotate engine.
// Depends on nothing; imported by every module of the block.
package mfr_pkg;

	localparam int MAX_DIM  = 128;
	localparam int HALF_MAX = MAX_DIM / 2;
	localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
	localparam int DIM_W    = $clog2(MAX_DIM) + 1;
	localparam int HALF_W   = $clog2(HALF_MAX) + 1;
	localparam int DATA_W   = 32;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_XFORM = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [2:0] OP_VFLIP   = 3'd0;
	localparam logic [2:0] OP_HFLIP   = 3'd1;
	localparam logic [2:0] OP_ROT_R   = 3'd2;
	localparam logic [2:0] OP_ROT_L   = 3'd3;
	localparam logic [2:0] OP_QUAD_CW = 3'd4;
	localparam logic [2:0] OP_QUAD_CC = 3'd5;

	typedef struct packed {
		logic load;      // write elem_in at load position
		logic rd_issue;  // read at read position
		logic rd_cap;    // capture read word into output register
		logic xf_start;  // latch op, clear walk counters
		logic xf_step;   // issue one source read of the walk
		logic xf_commit; // swap banks, finish transform
	} mfr_cmd_t;

	typedef struct packed {
		logic out_full;  // output register holds a word not yet taken
		logic walk_last; // walk counters point at the last element
	} mfr_sts_t;

endpackage

@@ rtl/mfr_ctrl.sv @@
// Controller state machine of the matrix flip/rotate engine.
// Depends on mfr_pkg; drives the datapath through mfr_cmd_t.
module mfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [2:0]        op,
	input  logic              out_ready,
	input  mfr_pkg::mfr_sts_t sts,
	output mfr_pkg::mfr_cmd_t cmd
);
	import mfr_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WALK, ST_DRAIN} state_t;

	state_t state_q;
	logic   acc;

	assign in_ready = (state_q == ST_IDLE) && (!sts.out_full || out_ready);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.load      = acc && (req_type == REQ_LOAD);
		cmd.rd_issue  = acc && (req_type == REQ_READ);
		cmd.xf_start  = acc && (req_type == REQ_XFORM) && (op <= OP_QUAD_CC);
		cmd.rd_cap    = (state_q == ST_READ);
		cmd.xf_step   = (state_q == ST_WALK);
		cmd.xf_commit = (state_q == ST_DRAIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.rd_issue) state_q <= ST_READ;
					else if (cmd.xf_start) state_q <= ST_WALK;
				end
				ST_READ:  state_q <= ST_IDLE;
				ST_WALK: begin
					if (sts.walk_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/mfr_dp.sv @@
// Datapath of the matrix flip/rotate engine: two banks of element memory,
// dimensions, positions, transform walk and output register. Depends on mfr_pkg.
module mfr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mfr_pkg::HALF_W-1:0] cfg_data,
	input  logic [mfr_pkg::DATA_W-1:0] elem_in,
	input  logic [2:0]                 op,
	input  logic                       out_ready,
	input  mfr_pkg::mfr_cmd_t          cmd,
	output mfr_pkg::mfr_sts_t          sts,
	output logic                       out_valid,
	output logic [mfr_pkg::DATA_W-1:0] elem_out,
	output logic                       row_end,
	output logic                       last
);
	import mfr_pkg::*;

	logic [DATA_W-1:0] mem0 [MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] mem1 [MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] rd0_q, rd1_q;

	logic [HALF_W-1:0] rh_q, ch_q, cfg_clamp;
	logic [ADDR_W-1:0] load_pos_q, read_pos_q, cnt_m1;
	logic [DIM_W-1:0]  read_col_q;
	logic              bank_q, out_valid_q, pend_end_q, pend_last_q;
	logic              row_end_q, last_q;
	logic [DATA_W-1:0] elem_q;

	logic [2:0]        op_q;
	logic [DIM_W-1:0]  i_q, j_q;
	logic [ADDR_W-1:0] dst_q, dst_s1;
	logic              wr_s1;

	logic [DIM_W-1:0]  rr, cc, nr, nc, si, sj, nn, mm;
	logic [2*DIM_W-1:0] prod;
	logic [ADDR_W-1:0] src_addr, raddr;
	logic [ADDR_W:0]   cnt;
	logic              rot, rd_end, rd_last;

	assign rr  = {rh_q, 1'b0};
	assign cc  = {ch_q, 1'b0};
	assign nn  = DIM_W'(rh_q);
	assign mm  = DIM_W'(ch_q);
	assign rot = (op_q == OP_ROT_R) || (op_q == OP_ROT_L);
	assign nr  = rot ? cc : rr;
	assign nc  = rot ? rr : cc;
	assign cnt    = (ADDR_W+1)'({(2*HALF_W)'(rh_q) * (2*HALF_W)'(ch_q), 2'b00});
	assign cnt_m1 = ADDR_W'(cnt - 1'b1);

	assign cfg_clamp = (cfg_data == '0) ? HALF_W'(1) :
		(cfg_data > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : cfg_data;

	// Source coordinate of destination (i, j).
	always_comb begin
		si = i_q;
		sj = j_q;
		case (op_q)
			OP_VFLIP: si = rr - 1'b1 - i_q;
			OP_HFLIP: sj = cc - 1'b1 - j_q;
			OP_ROT_R: begin si = rr - 1'b1 - j_q; sj = i_q; end
			OP_ROT_L: begin si = j_q; sj = cc - 1'b1 - i_q; end
			OP_QUAD_CW: begin
				if (i_q < nn && j_q < mm) si = i_q + nn;
				else if (i_q < nn) sj = j_q - mm;
				else if (j_q < mm) sj = j_q + mm;
				else si = i_q - nn;
			end
			default: begin
				if (i_q < nn && j_q < mm) sj = j_q + mm;
				else if (i_q < nn) si = i_q + nn;
				else if (j_q < mm) si = i_q - nn;
				else sj = j_q - mm;
			end
		endcase
	end

	assign prod     = si * cc;
	assign src_addr = prod[ADDR_W-1:0] + ADDR_W'(sj);
	assign raddr    = cmd.xf_step ? src_addr : read_pos_q;
	assign sts.walk_last = (i_q == nr - 1'b1) && (j_q == nc - 1'b1);
	assign sts.out_full  = out_valid_q;
	assign rd_end  = (read_col_q == cc - 1'b1);
	assign rd_last = (read_pos_q == cnt_m1);

	// Bank memories: loads go to the live bank, walk writes to the other.
	always_ff @(posedge clk) begin
		rd0_q <= mem0[raddr];
		if (cmd.load && !bank_q) mem0[load_pos_q] <= elem_in;
		else if (wr_s1 && bank_q) mem0[dst_s1] <= bank_q ? rd1_q : rd0_q;
	end

	always_ff @(posedge clk) begin
		rd1_q <= mem1[raddr];
		if (cmd.load && bank_q) mem1[load_pos_q] <= elem_in;
		else if (wr_s1 && !bank_q) mem1[dst_s1] <= bank_q ? rd1_q : rd0_q;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		dst_s1 <= dst_q;
		if (cmd.xf_start) op_q <= op;
		if (cmd.rd_issue) begin
			pend_end_q  <= rd_end;
			pend_last_q <= rd_last;
		end
		if (cmd.rd_cap) begin
			elem_q    <= bank_q ? rd1_q : rd0_q;
			row_end_q <= pend_end_q;
			last_q    <= pend_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rh_q        <= HALF_W'(1);
			ch_q        <= HALF_W'(1);
			load_pos_q  <= '0;
			read_pos_q  <= '0;
			read_col_q  <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			dst_q       <= '0;
			wr_s1       <= 1'b0;
		end else begin
			wr_s1 <= cmd.xf_step;
			if (cfg_we) begin
				if (cfg_index) ch_q <= cfg_clamp;
				else rh_q <= cfg_clamp;
				load_pos_q <= '0;
				read_pos_q <= '0;
				read_col_q <= '0;
			end
			if (cmd.load) begin
				load_pos_q <= (load_pos_q == cnt_m1) ? '0 : load_pos_q + 1'b1;
			end
			if (cmd.rd_issue) begin
				read_pos_q <= rd_last ? '0 : read_pos_q + 1'b1;
				read_col_q <= rd_end ? '0 : read_col_q + 1'b1;
			end
			if (cmd.rd_cap) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.xf_start) begin
				i_q   <= '0;
				j_q   <= '0;
				dst_q <= '0;
			end else if (cmd.xf_step) begin
				dst_q <= dst_q + 1'b1;
				if (j_q == nc - 1'b1) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.xf_commit) begin
				bank_q     <= !bank_q;
				read_pos_q <= '0;
				read_col_q <= '0;
				if (rot) begin
					rh_q <= ch_q;
					ch_q <= rh_q;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign elem_out  = elem_q;
	assign row_end   = row_end_q;
	assign last      = last_q;

endmodule

@@ rtl/matrix_flip_rotate_engine.sv @@
// Top level of the matrix flip/rotate engine: controller plus datapath.
// Depends on mfr_pkg, mfr_ctrl and mfr_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   in      | in_valid / in_ready  | req_type, elem_in, op
//   out     | out_valid / out_ready| elem_out, row_end, last
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// A load word is written directly; a read word passes the registered bank
// memory read and then the output register. A transform holds off input while
// it makes one memory read per element, written into the other bank, then a
// drain state that writes the last element and swaps banks. Reset clears
// dimensions to 2x2 and positions to zero; element memory is not cleared. Input
// stalls while the output register holds a word and out_ready is low.
module matrix_flip_rotate_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [mfr_pkg::HALF_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic signed [31:0]         elem_in,
	input  logic [2:0]                 op,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         elem_out,
	output logic                       row_end,
	output logic                       last
);
	import mfr_pkg::*;

	mfr_cmd_t cmd;
	mfr_sts_t sts;

	// Sequence load, read and transform words.
	mfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.op       (op),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the matrix and walk it on a transform.
	mfr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.elem_in  (elem_in),
		.op       (op),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.elem_out (elem_out),
		.row_end  (row_end),
		.last     (last)
	);

	// The last step of the walk is followed directly by the drain.
	a_walk_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.xf_step && sts.walk_last |=> cmd.xf_commit)
		else $error("walk end not followed by drain");

	// A capture only follows an accepted read word.
	a_cap_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_cap |-> $past(in_valid && in_ready && req_type == REQ_READ))
		else $error("capture without read");

	// No input is taken while the walk runs.
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.xf_step || cmd.xf_commit) |-> !in_ready)
		else $error("input taken during transform");

endmodule
